/* sv/salts_pkg.sv */
// Package for the set-associative LRU tag store: payload types and sequencer states.
`timescale 1ns / 1ps
package salts_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] address;
    logic        write_or_dirty;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic        victim_valid;
    logic [31:0] victim_address;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_WRITE,
    ST_DONE
  } state_t;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

endpackage

/* sv/salts_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module salts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/set_assoc_lru_tag_store_core.sv */
// An accepted command is handled alone: cmd_stall holds off the next until the sequencer is idle.
// The single read and write port of each RAM visits one way of the set per cycle: WAYS reads,
// then WAYS recency write-backs (none on a lookup miss).
// The response sits in an output register, so the next command is taken while it waits.
// Reset: synchronous, clears the sequencer and the valid bits; a set with no valid
// way reads its recency in way order, so the RAM contents need no clearing pass.
`timescale 1ns / 1ps
module set_assoc_lru_tag_store_core #(
  parameter int ADDR_BITS  = 32,
  parameter int BLOCK_BITS = 6,
  parameter int SET_BITS   = 6,
  parameter int ASSOC_BITS = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  salts_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output salts_pkg::rsp_t rsp
);

  import salts_pkg::*;

  localparam int WAYS    = 1 << ASSOC_BITS;
  localparam int ENTRIES = 1 << (SET_BITS + ASSOC_BITS);
  localparam int ENTRY_W = (SET_BITS + ASSOC_BITS > 0) ? SET_BITS + ASSOC_BITS : 1;
  localparam int SET_W   = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int POS_W   = (ASSOC_BITS > 0) ? ASSOC_BITS : 1;
  localparam int CNT_W   = ASSOC_BITS + 1;
  localparam int TAG_W   = ADDR_BITS - BLOCK_BITS - SET_BITS;
  localparam logic [63:0] ADDR_MASK = (ADDR_BITS >= 64) ? {64{1'b1}} :
                                      ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [63:0] SET_MASK  = (64'd1 << SET_BITS) - 64'd1;
  localparam logic [POS_W-1:0] LRU_POS = POS_W'(WAYS - 1);
  localparam logic [CNT_W-1:0] LAST_WAY = CNT_W'(WAYS - 1);
  localparam logic [CNT_W-1:0] NUM_WAYS = CNT_W'(WAYS);

  // Sequencer and control registers
  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               pend, pend_next;
  logic [CNT_W-1:0]   ret_way, ret_way_next;
  logic [ENTRY_W-1:0] ret_entry, ret_entry_next;
  logic               valid_bits [ENTRIES];
  logic               rsp_valid_r, rsp_valid_next;

  // Item and scan registers
  logic               func_r, flag_r;
  logic [SET_W-1:0]   set_r;
  logic [TAG_W-1:0]   tag_r;
  logic               found, found_next;
  logic [CNT_W-1:0]   dest, dest_next;
  logic               dest_dirty, dest_dirty_next;
  logic               vict, vict_next;
  logic [TAG_W-1:0]   vict_tag, vict_tag_next;
  logic [POS_W-1:0]   cur_pos, cur_pos_next;
  logic [POS_W-1:0]   pos_r [WAYS];
  logic [POS_W-1:0]   pos_r_next [WAYS];
  rsp_t               rsp_r, rsp_next;

  // Item fields from the command
  logic [63:0]        cmd_addr;
  logic [SET_W-1:0]   cmd_set;
  logic [TAG_W-1:0]   cmd_tag;

  // RAM ports
  logic [ENTRY_W-1:0] raddr, waddr;
  logic               tag_we, pos_we;
  logic [TAG_W:0]     tag_wdata, tag_rdata;
  logic [POS_W-1:0]   pos_wdata, pos_rdata;

  // Datapath helpers
  logic               way_valid;
  logic [POS_W-1:0]   way_pos;
  logic [POS_W-1:0]   wr_old_pos;
  logic               set_valid_bit;
  logic               set_used;
  logic [63:0]        vict_addr;

  assign cmd_addr = {32'd0, cmd.address} & ADDR_MASK;
  assign cmd_set  = SET_W'((cmd_addr >> BLOCK_BITS) & SET_MASK);
  assign cmd_tag  = TAG_W'(cmd_addr >> (BLOCK_BITS + SET_BITS));

  salts_ram #(.WIDTH(TAG_W + 1), .DEPTH(ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (waddr),
    .wdata (tag_wdata),
    .raddr (raddr),
    .rdata (tag_rdata)
  );

  salts_ram #(.WIDTH(POS_W), .DEPTH(ENTRIES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (waddr),
    .wdata (pos_wdata),
    .raddr (raddr),
    .rdata (pos_rdata)
  );

  assign cmd_stall = (state != ST_IDLE);
  assign rsp_valid = rsp_valid_r;
  assign rsp       = rsp_r;

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (pend && (ret_way == LAST_WAY)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if ((func_r == FUNC_LOOKUP) && !found) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (cnt == LAST_WAY) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_r || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cnt_next        = cnt;
    pend_next       = 1'b0;
    ret_way_next    = ret_way;
    ret_entry_next  = ret_entry;
    found_next      = found;
    dest_next       = dest;
    dest_dirty_next = dest_dirty;
    vict_next       = vict;
    vict_tag_next   = vict_tag;
    cur_pos_next    = cur_pos;
    pos_r_next      = pos_r;
    rsp_next        = rsp_r;
    rsp_valid_next  = rsp_valid_r;
    raddr           = (ENTRY_W'(set_r) << ASSOC_BITS) | ENTRY_W'(cnt);
    waddr           = (ENTRY_W'(set_r) << ASSOC_BITS) | ENTRY_W'(cnt);
    tag_we          = 1'b0;
    pos_we          = 1'b0;
    tag_wdata       = {1'b0, tag_r};
    pos_wdata       = '0;
    set_valid_bit   = 1'b0;
    wr_old_pos      = '0;

    // Every write to a set validates one of its ways, so a set with no valid way has never
    // been written; its recency is then taken in way order instead of from the RAM.
    set_used = 1'b0;
    for (int a = 0; a < WAYS; a++) begin
      if (valid_bits[(ENTRY_W'(set_r) << ASSOC_BITS) | ENTRY_W'(a)]) begin
        set_used = 1'b1;
      end
    end
    way_valid = valid_bits[ret_entry];
    way_pos   = set_used ? pos_rdata : POS_W'(ret_way);

    vict_addr = ((64'(vict_tag) << SET_BITS) | 64'(set_r)) << BLOCK_BITS;

    if (rsp_valid_r && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        cnt_next   = '0;
        found_next = 1'b0;
        vict_next  = 1'b0;
        dest_next  = '0;
      end
      ST_READ: begin
        if (cnt != NUM_WAYS) begin
          pend_next      = 1'b1;
          ret_way_next   = cnt;
          ret_entry_next = raddr;
          cnt_next       = cnt + CNT_W'(1);
        end
        if (pend) begin
          for (int a = 0; a < WAYS; a++) begin
            if (ret_way == CNT_W'(a)) begin
              pos_r_next[a] = way_pos;
            end
          end
          if (!found) begin
            if (func_r == FUNC_LOOKUP) begin
              if (way_valid && (tag_rdata[TAG_W-1:0] == tag_r)) begin
                found_next      = 1'b1;
                dest_next       = ret_way;
                dest_dirty_next = tag_rdata[TAG_W];
              end
            end else begin
              if (!way_valid) begin
                found_next = 1'b1;
                dest_next  = ret_way;
              end else if (way_pos == LRU_POS) begin
                found_next    = 1'b1;
                dest_next     = ret_way;
                vict_next     = tag_rdata[TAG_W];
                vict_tag_next = tag_rdata[TAG_W-1:0];
              end
            end
          end
        end
      end
      ST_DECIDE: begin
        cnt_next = '0;
        for (int a = 0; a < WAYS; a++) begin
          if (dest == CNT_W'(a)) begin
            cur_pos_next = pos_r[a];
          end
        end
      end
      ST_WRITE: begin
        for (int a = 0; a < WAYS; a++) begin
          if (cnt == CNT_W'(a)) begin
            wr_old_pos = pos_r[a];
          end
        end
        pos_we      = 1'b1;
        if (cnt == dest) begin
          pos_wdata     = '0;
          tag_we        = 1'b1;
          set_valid_bit = 1'b1;
          if (func_r == FUNC_INSERT) begin
            tag_wdata = {flag_r, tag_r};
          end else begin
            tag_wdata = {dest_dirty | flag_r, tag_r};
          end
        end else if (wr_old_pos < cur_pos) begin
          pos_wdata = wr_old_pos + POS_W'(1);
        end else begin
          pos_wdata = wr_old_pos;
        end
        cnt_next = cnt + CNT_W'(1);
      end
      ST_DONE: begin
        if (!rsp_valid_r || !rsp_stall) begin
          rsp_valid_next      = 1'b1;
          rsp_next.hit        = (func_r == FUNC_LOOKUP) && found;
          rsp_next.victim_valid = (func_r == FUNC_INSERT) && vict;
          rsp_next.victim_address = ((func_r == FUNC_INSERT) && vict) ? vict_addr[31:0] : 32'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      pend        <= 1'b0;
      rsp_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_bits[i] <= 1'b0;
      end
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      pend        <= pend_next;
      rsp_valid_r <= rsp_valid_next;
      if (set_valid_bit) begin
        valid_bits[waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && cmd_valid) begin
      func_r <= cmd.func;
      flag_r <= cmd.write_or_dirty;
      set_r  <= cmd_set;
      tag_r  <= cmd_tag;
    end
    ret_way    <= ret_way_next;
    ret_entry  <= ret_entry_next;
    found      <= found_next;
    dest       <= dest_next;
    dest_dirty <= dest_dirty_next;
    vict       <= vict_next;
    vict_tag   <= vict_tag_next;
    cur_pos    <= cur_pos_next;
    pos_r      <= pos_r_next;
    rsp_r      <= rsp_next;
  end

endmodule
